### hw/rtl/pofs_pkg.sv
// Shared types, field widths and codes for the PWM output flash sequencer.
package pofs_pkg;

    // Field widths of the input and result words.
    localparam int IDX_W  = 4;
    localparam int KIND_W = 2;
    localparam int LVL_W  = 11;
    localparam int DUR_W  = 16;
    localparam int OIDX_W = 3;
    localparam int OLVL_W = 10;

    // Bus widths, padded to whole bytes.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;

    // Bit offsets of the input fields inside the slave tdata.
    localparam int OFS_IDX     = 0;
    localparam int OFS_KIND    = OFS_IDX + IDX_W;
    localparam int OFS_LVL_ON  = OFS_KIND + KIND_W;
    localparam int OFS_LVL_OFF = OFS_LVL_ON + LVL_W;
    localparam int OFS_DUR_ON  = OFS_LVL_OFF + LVL_W;
    localparam int OFS_DUR_OFF = OFS_DUR_ON + DUR_W;

    // Defaults of the top-level parameters.
    localparam int DEF_NUM_OUTPUTS = 8;
    localparam int DEF_PWM_MAX     = 1023;

    // At most this many words are reported for one input word.
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = 5;

    // Codes of the tuser selector.
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_SET  = 1'b1;

    // Cycle kinds; the unused code behaves as direct.
    localparam logic [KIND_W-1:0] KIND_DIRECT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ONESHOT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLASH   = 2'd2;

    // One stored cycle of an output.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LVL_W-1:0]  lvl_on;
        logic [LVL_W-1:0]  lvl_off;
        logic [DUR_W-1:0]  dur_on;
        logic [DUR_W-1:0]  dur_off;
    } t_cycle;

    localparam t_cycle IDLE_CYCLE = '0;

    // One pending level write inside the sequencer.
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic [LVL_W-1:0] level;
    } t_res;

    // Command from the sequencer to the output buffer.
    typedef struct packed {
        logic             push;
        logic             flush;
        logic [IDX_W-1:0] idx;
        logic [LVL_W-1:0] level;
    } t_res_cmd;

endpackage

### hw/rtl/pofs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pofs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/pofs_obuf.sv
// Output buffer: holds back one level write until it is known whether it is the last.
module pofs_obuf (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pofs_pkg::t_res_cmd                  i_cmd,
    output logic                                o_cmd_ready,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [pofs_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                                o_m_tlast
);
    import pofs_pkg::*;

    logic              r_p_vld;
    logic [IDX_W-1:0]  r_p_idx;
    logic [LVL_W-1:0]  r_p_lvl;
    logic              r_o_vld;
    logic [OIDX_W-1:0] r_o_idx;
    logic [OLVL_W-1:0] r_o_lvl;
    logic              r_o_last;
    logic              out_free;
    logic              cmd_acc;

    // The output register frees up when empty or taken this cycle.
    assign out_free    = !r_o_vld || i_m_tready;
    assign o_cmd_ready = !r_p_vld || out_free;
    assign cmd_acc     = (i_cmd.push || i_cmd.flush) && o_cmd_ready;

    // A new word or the end of the item moves the held word to the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (cmd_acc && r_p_vld) begin
                r_o_vld  <= 1'b1;
                r_o_idx  <= r_p_idx[OIDX_W-1:0];
                r_o_lvl  <= r_p_lvl[OLVL_W-1:0];
                r_o_last <= i_cmd.flush;
            end else if (r_o_vld && i_m_tready) begin
                r_o_vld <= 1'b0;
            end
            if (cmd_acc) begin
                r_p_vld <= i_cmd.push;
                r_p_idx <= i_cmd.idx;
                r_p_lvl <= i_cmd.level;
            end
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {{(M_TDATA_W - OIDX_W - OLVL_W){1'b0}}, r_o_lvl, r_o_idx};
    assign o_m_tlast  = r_o_last;

endmodule

### hw/rtl/pofs_seq.sv
// Sequencer: decodes input words and read-modify-writes the active and queued cycle memories.
module pofs_seq #(
    parameter int NUM_OUTPUTS = pofs_pkg::DEF_NUM_OUTPUTS,
    parameter int PWM_MAX     = pofs_pkg::DEF_PWM_MAX,
    parameter int AW          = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [pofs_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic                               i_s_tuser,
    output logic                               o_mem_re,
    output logic [AW-1:0]                      o_mem_raddr,
    output logic [AW-1:0]                      o_mem_waddr,
    output logic                               o_act_we,
    output pofs_pkg::t_cycle                   o_act_wdata,
    input  pofs_pkg::t_cycle                   i_act_rdata,
    output logic                               o_q_we,
    output pofs_pkg::t_cycle                   o_q_wdata,
    input  pofs_pkg::t_cycle                   i_q_rdata,
    output pofs_pkg::t_res_cmd                 o_cmd,
    input  logic                               i_cmd_ready
);
    import pofs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SET, S_READ, S_CALC, S_EMIT, S_FLUSH
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_set_idx, n_set_idx;
    t_cycle             r_set_cyc, n_set_cyc;
    logic               r_is_set, n_is_set;
    logic [AW-1:0]      r_idx, n_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_res               r_r1, n_r1;
    t_res               r_r2, n_r2;
    logic [NUM_OUTPUTS-1:0] r_a_vld, n_a_vld;
    logic [NUM_OUTPUTS-1:0] r_q_vld, n_q_vld;

    t_cycle             a_eff;
    t_cycle             q_eff;
    t_cycle             na;
    logic               set_ok;
    logic [AW-1:0]      set_addr;
    logic [IDX_W-1:0]   idx_ext;
    logic               is_last;
    logic               s_acc;
    logic               lim_hit;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign set_addr   = r_set_idx[AW-1:0];
    assign idx_ext    = IDX_W'(r_idx);
    assign is_last    = (r_idx == AW'(NUM_OUTPUTS - 1));
    assign lim_hit    = (r_cnt == CNT_W'(RESULT_LIMIT));

    // A set is taken only for an existing output and levels within range.
    assign set_ok = ({1'b0, r_set_idx} < (IDX_W + 1)'(NUM_OUTPUTS))
                 && (r_set_cyc.lvl_on <= LVL_W'(PWM_MAX))
                 && (r_set_cyc.lvl_off <= LVL_W'(PWM_MAX));

    // Entries never written since reset read as the idle cycle.
    assign a_eff = r_a_vld[r_idx] ? i_act_rdata : IDLE_CYCLE;
    assign q_eff = r_q_vld[r_idx] ? i_q_rdata : IDLE_CYCLE;

    // Next active cycle and level writes of the output under a tick.
    always_comb begin
        na   = a_eff;
        n_r1 = r_r1;
        n_r2 = r_r2;
        if (r_state == S_CALC) begin
            n_r1 = '0;
            n_r2 = '0;
            if (a_eff.kind != KIND_ONESHOT && a_eff.kind != KIND_FLASH) begin
                na = q_eff;
            end else if (a_eff.dur_on != '0) begin
                na.dur_on = a_eff.dur_on - 1'b1;
                n_r1      = '{vld: 1'b1, idx: idx_ext, level: a_eff.lvl_on};
            end else if (a_eff.dur_off != '0) begin
                na.dur_off = a_eff.dur_off - 1'b1;
                n_r1       = '{vld: 1'b1, idx: idx_ext, level: a_eff.lvl_off};
                if (a_eff.dur_off == DUR_W'(1)) begin
                    if (a_eff.kind == KIND_ONESHOT) begin
                        na   = IDLE_CYCLE;
                        n_r2 = '{vld: 1'b1, idx: idx_ext, level: '0};
                    end else begin
                        na = q_eff;
                    end
                end
            end
        end
    end

    // Control path: item decode, memory walk and result hand-off.
    always_comb begin
        n_state     = r_state;
        n_set_idx   = r_set_idx;
        n_set_cyc   = r_set_cyc;
        n_is_set    = r_is_set;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_a_vld     = r_a_vld;
        n_q_vld     = r_q_vld;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx;
        o_mem_waddr = r_idx;
        o_act_we    = 1'b0;
        o_act_wdata = na;
        o_q_we      = 1'b0;
        o_q_wdata   = IDLE_CYCLE;
        o_cmd       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_set_idx = i_s_tdata[OFS_IDX +: IDX_W];
                    n_set_cyc = '{kind:    i_s_tdata[OFS_KIND +: KIND_W],
                                  lvl_on:  i_s_tdata[OFS_LVL_ON +: LVL_W],
                                  lvl_off: i_s_tdata[OFS_LVL_OFF +: LVL_W],
                                  dur_on:  i_s_tdata[OFS_DUR_ON +: DUR_W],
                                  dur_off: i_s_tdata[OFS_DUR_OFF +: DUR_W]};
                    n_cnt     = '0;
                    n_idx     = '0;
                    n_is_set  = (i_s_tuser == MODE_SET);
                    n_state   = (i_s_tuser == MODE_SET) ? S_SET : S_READ;
                end
            end
            S_SET: begin
                if (set_ok) begin
                    o_mem_waddr       = set_addr;
                    o_q_we            = 1'b1;
                    o_q_wdata         = r_set_cyc;
                    n_q_vld[set_addr] = 1'b1;
                    if (r_set_cyc.kind != KIND_ONESHOT && r_set_cyc.kind != KIND_FLASH) begin
                        o_act_we          = 1'b1;
                        o_act_wdata       = r_set_cyc;
                        n_a_vld[set_addr] = 1'b1;
                        n_state           = S_EMIT;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_mem_re = 1'b1;
                n_state  = S_CALC;
            end
            S_CALC: begin
                // Write back this entry and prefetch the next one.
                o_act_we       = 1'b1;
                n_a_vld[r_idx] = 1'b1;
                if (n_r2.vld) begin
                    o_q_we         = 1'b1;
                    n_q_vld[r_idx] = 1'b1;
                end
                if (!is_last) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx + 1'b1;
                end
                if (n_r1.vld) begin
                    n_state = S_EMIT;
                end else if (is_last) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                if (r_r1.vld || r_r2.vld) begin
                    // Words past the limit are dropped.
                    o_cmd.push  = !lim_hit;
                    o_cmd.idx   = r_r1.vld ? r_r1.idx : r_r2.idx;
                    o_cmd.level = r_r1.vld ? r_r1.level : r_r2.level;
                    if (lim_hit || i_cmd_ready) begin
                        if (!lim_hit) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                end else if (r_is_set || is_last) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CALC;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (i_cmd_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a_vld <= '0;
            r_q_vld <= '0;
            r_r1    <= '0;
            r_r2    <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_is_set <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_a_vld  <= n_a_vld;
            r_q_vld  <= n_q_vld;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_is_set <= n_is_set;
            if (r_state == S_SET) begin
                r_r1 <= '{vld: 1'b1, idx: r_set_idx, level: r_set_cyc.lvl_on};
                r_r2 <= '0;
            end else if (r_state == S_EMIT) begin
                // Retire the front word once it is taken or dropped.
                if (r_r1.vld && (lim_hit || i_cmd_ready)) begin
                    r_r1 <= '0;
                end else if (!r_r1.vld && r_r2.vld && (lim_hit || i_cmd_ready)) begin
                    r_r2 <= '0;
                end
            end else begin
                r_r1 <= n_r1;
                r_r2 <= n_r2;
            end
        end
    end

    // Payload of the accepted word.
    always_ff @(posedge i_clk) begin
        r_set_idx <= n_set_idx;
        r_set_cyc <= n_set_cyc;
    end

endmodule

### hw/rtl/pwm_output_flash_sequencer.sv
// Top level of the PWM output flash sequencer.
//
// The slave channel takes one word per command: tuser selects a tick (0) or a
// set of one output's cycle (1); tdata carries the set fields and is ignored
// by a tick. The master channel delivers one word per PWM level write, with
// tlast on the last write caused by a command; a command may cause none.
// Output cycles live in two small RAMs (active and queued) with registered
// reads; a tick walks the outputs in index order, reading the next entry
// while the current one is written back.
// The slave accepts a new word only when the previous command is finished.
// When the receiver stalls, one write is held in the output register and one
// more in the holding stage; the walk then waits until space frees up.
// After reset every output reads as direct with zero levels and durations,
// through per-entry valid bits, so the block is ready at once.
module pwm_output_flash_sequencer #(
    parameter int NUM_OUTPUTS = pofs_pkg::DEF_NUM_OUTPUTS,
    parameter int PWM_MAX     = pofs_pkg::DEF_PWM_MAX
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // target_index, cycle_kind, level_on, level_off, ticks_on, ticks_off
    input  logic [pofs_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // mode
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // drive_index, drive_level
    output logic [pofs_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast
);
    import pofs_pkg::*;

    localparam int AW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_waddr;
    logic          act_we;
    t_cycle        act_wdata;
    t_cycle        act_rdata;
    logic          q_we;
    t_cycle        q_wdata;
    t_cycle        q_rdata;
    t_res_cmd      cmd;
    logic          cmd_ready;

    // Active cycle of each output.
    pofs_ram #(
        .WIDTH ($bits(t_cycle)),
        .DEPTH (NUM_OUTPUTS),
        .AW    (AW)
    ) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (act_we),
        .i_waddr (mem_waddr),
        .i_wdata (act_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (act_rdata)
    );

    // Queued cycle of each output.
    pofs_ram #(
        .WIDTH ($bits(t_cycle)),
        .DEPTH (NUM_OUTPUTS),
        .AW    (AW)
    ) u_q_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (mem_waddr),
        .i_wdata (q_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (q_rdata)
    );

    // Command decode and memory walk.
    pofs_seq #(
        .NUM_OUTPUTS (NUM_OUTPUTS),
        .PWM_MAX     (PWM_MAX),
        .AW          (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_mem_waddr (mem_waddr),
        .o_act_we    (act_we),
        .o_act_wdata (act_wdata),
        .i_act_rdata (act_rdata),
        .o_q_we      (q_we),
        .o_q_wdata   (q_wdata),
        .i_q_rdata   (q_rdata),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    // Level writes toward the receiver.
    pofs_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
